/* hw/rtl/utf8d_pkg.sv */
// ----------------------------------------------------------------------------
// utf8d_pkg: shared types and constants of the UTF-8 decoder
// Result word layout, byte class patterns, count cap and separator resets.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  // Counter width of the string counts; the result fields are 16 bits wide
  localparam int COUNT_BITS = 16;
  localparam int CountW     = 16;
  localparam logic [CountW-1:0] CountCap =
      (COUNT_BITS >= CountW) ? {CountW{1'b1}} : CountW'((64'd1 << COUNT_BITS) - 64'd1);

  // Codepoint width and the replacement codepoint
  localparam int CpW = 21;
  localparam logic [CpW-1:0] Replacement = 21'h00FFFD;

  // Separator registers
  localparam int NumSep   = 4;
  localparam int SepIdxW  = $clog2(NumSep);
  localparam int CfgIdxW  = 8;
  typedef logic [NumSep-1:0][CpW-1:0] sep_set_t;
  localparam sep_set_t SepReset = {21'd0, 21'd9, 21'd10, 21'd32};

  // Byte class patterns
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContVal   = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Val  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Val  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Val  = 8'hF0;

  // Result queue
  localparam int ResDepth = 4;
  localparam int ResPtrW  = $clog2(ResDepth);

  typedef enum logic {
    KIND_CODE    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [CpW-1:0]    code_value;
    logic              bad_encoding;
    logic              matches_separator;
    logic [CountW-1:0] total_codepoints;
    logic [CountW-1:0] word_chars;
    logic              last_of_run;
  } result_t;

  // Up to two results written to the queue in one cycle, r0 first
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

endpackage

/* hw/rtl/utf8d_decode.sv */
// ----------------------------------------------------------------------------
// utf8d_decode: input register, decode state and result generation
// Decodes the registered byte against the sequence state in one pass and
// hands up to two result words per byte to the result queue.
// ----------------------------------------------------------------------------
module utf8d_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_byte_i,
  input  utf8d_pkg::sep_set_t sep_i,
  input  logic                room_i,
  output utf8d_pkg::push_t    push_o
);
  import utf8d_pkg::*;

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              fire;

  logic [1:0]        pend_q, pend_d;
  logic              skip_q, skip_d;
  logic [CpW-1:0]    part_q, part_d;
  logic [CountW-1:0] tally_q, wtally_q;
  logic              closed_q;

  logic              cont;
  logic              lead_go;
  logic [CpW-1:0]    part_n;
  logic              pre_v, main_v, main_sum, main_bad;
  logic [CpW-1:0]    main_cp;
  logic              pre_match, main_match, main_cnt;
  logic [CountW-1:0] t1, t2, w1, w2;
  logic              closed1, closed2;
  result_t           pre_res, main_res;

  function automatic logic is_sep(logic [CpW-1:0] cp, sep_set_t s);
    logic m;
    m = 1'b0;
    for (int i = 0; i < NumSep; i++) begin
      m = m | ((s[i] != '0) && (cp == s[i]));
    end
    return m;
  endfunction

  function automatic logic [CountW-1:0] sat_inc(logic [CountW-1:0] x);
    return (x < CountCap) ? x + CountW'(1) : x;
  endfunction

  // Hold the byte until the result queue has room for two words
  assign fire       = in_valid_q && room_i;
  assign in_ready_o = !in_valid_q || room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
    end
  end

  // Classify the byte and advance the sequence state
  always_comb begin
    cont     = (in_byte_q & ContMask) == ContVal;
    part_n   = {part_q[CpW-7:0], in_byte_q[5:0]};
    pend_d   = pend_q;
    skip_d   = skip_q;
    part_d   = part_q;
    lead_go  = 1'b0;
    pre_v    = 1'b0;
    main_v   = 1'b0;
    main_sum = 1'b0;
    main_bad = 1'b0;
    main_cp  = '0;

    if (in_byte_q == 8'h00) begin
      // end of string: flush an unfinished sequence, then the summary
      pre_v    = (pend_q != 2'd0);
      main_v   = 1'b1;
      main_sum = 1'b1;
    end else if (skip_q && cont) begin
      // drop stray continuation byte
    end else if (pend_q != 2'd0) begin
      if (cont) begin
        pend_d = pend_q - 2'd1;
        part_d = part_n;
        if (pend_q == 2'd1) begin
          main_v  = 1'b1;
          main_cp = part_n;
          part_d  = '0;
        end
      end else begin
        // interrupted sequence: replace, then decode this byte as a lead
        pre_v   = 1'b1;
        pend_d  = 2'd0;
        part_d  = '0;
        lead_go = 1'b1;
      end
    end else begin
      skip_d  = 1'b0;
      lead_go = 1'b1;
    end

    if (lead_go) begin
      if (!in_byte_q[7]) begin
        main_v  = 1'b1;
        main_cp = CpW'(in_byte_q);
      end else if ((in_byte_q & Lead2Mask) == Lead2Val) begin
        pend_d = 2'd1;
        part_d = CpW'(in_byte_q[4:0]);
      end else if ((in_byte_q & Lead3Mask) == Lead3Val) begin
        pend_d = 2'd2;
        part_d = CpW'(in_byte_q[3:0]);
      end else if ((in_byte_q & Lead4Mask) == Lead4Val) begin
        pend_d = 2'd3;
        part_d = CpW'(in_byte_q[2:0]);
      end else begin
        main_v   = 1'b1;
        main_cp  = Replacement;
        main_bad = 1'b1;
        skip_d   = 1'b1;
      end
    end
  end

  // Update the counts for the replacement word, then for the main word
  always_comb begin
    pre_match  = is_sep(Replacement, sep_i);
    t1         = pre_v ? sat_inc(tally_q) : tally_q;
    closed1    = closed_q || (pre_v && pre_match);
    w1         = (pre_v && !pre_match && !closed_q) ? sat_inc(wtally_q) : wtally_q;

    main_cnt   = main_v && !main_sum;
    main_match = main_cnt && is_sep(main_cp, sep_i);
    t2         = main_cnt ? sat_inc(t1) : t1;
    closed2    = closed1 || main_match;
    w2         = (main_cnt && !main_match && !closed1) ? sat_inc(w1) : w1;

    pre_res.kind              = KIND_CODE;
    pre_res.code_value        = Replacement;
    pre_res.bad_encoding      = 1'b1;
    pre_res.matches_separator = pre_match;
    pre_res.total_codepoints  = t1;
    pre_res.word_chars        = w1;
    pre_res.last_of_run       = !main_v;

    main_res.kind              = main_sum ? KIND_SUMMARY : KIND_CODE;
    main_res.code_value        = main_cp;
    main_res.bad_encoding      = main_bad;
    main_res.matches_separator = main_match;
    main_res.total_codepoints  = t2;
    main_res.word_chars        = w2;
    main_res.last_of_run       = 1'b1;
  end

  assign push_o.v0 = fire && (pre_v || main_v);
  assign push_o.v1 = fire && pre_v && main_v;
  assign push_o.r0 = pre_v ? pre_res : main_res;
  assign push_o.r1 = main_res;

  // Advance the string state; the end of string returns it to reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 2'd0;
      skip_q   <= 1'b0;
      part_q   <= '0;
      tally_q  <= '0;
      wtally_q <= '0;
      closed_q <= 1'b0;
    end else if (fire) begin
      if (main_sum) begin
        pend_q   <= 2'd0;
        skip_q   <= 1'b0;
        part_q   <= '0;
        tally_q  <= '0;
        wtally_q <= '0;
        closed_q <= 1'b0;
      end else begin
        pend_q   <= pend_d;
        skip_q   <= skip_d;
        part_q   <= part_d;
        tally_q  <= t2;
        wtally_q <= w2;
        closed_q <= closed2;
      end
    end
  end

`ifndef SYNTHESIS
  a_skip_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd0 |-> !skip_q)
    else $error("skipping while a sequence is pending");

  a_two_first_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.v1 |-> push_o.r0.bad_encoding && push_o.r0.code_value == Replacement)
    else $error("first of two words is not a replacement");

  a_word_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wtally_q <= tally_q)
    else $error("word count exceeds codepoint count");

  a_summary_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && main_sum |=> tally_q == '0 && pend_q == 2'd0 && !closed_q)
    else $error("string state not cleared after end of string");
`endif

endmodule

/* hw/rtl/utf8d_result_fifo.sv */
// ----------------------------------------------------------------------------
// utf8d_result_fifo: result word queue
// Takes up to two words per cycle from the decoder and delivers one word per
// cycle on the output channel while the output side is ready.
// ----------------------------------------------------------------------------
module utf8d_result_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  utf8d_pkg::push_t    push_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output utf8d_pkg::result_t  head_o
);
  import utf8d_pkg::*;

  localparam int CntW = ResPtrW + 1;

  result_t              mem_q [ResDepth];
  logic [ResPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]      cnt_q;
  logic                 pop;
  logic [CntW-1:0]      n_push;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign head_o      = mem_q[rd_ptr_q];
  assign room_o      = (cnt_q <= CntW'(ResDepth - 2));
  assign n_push      = CntW'(push_i.v0) + CntW'(push_i.v1);

  // Store incoming words in order
  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.v1) begin
      mem_q[wr_ptr_q + ResPtrW'(1)] <= push_i.r1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + ResPtrW'(n_push);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + ResPtrW'(1);
      end
      cnt_q <= cnt_q + n_push - CntW'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(ResDepth))
    else $error("result queue overflow");

  a_push_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.v1 |-> push_i.v0)
    else $error("second word pushed without the first");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.v0 |-> room_o)
    else $error("word pushed without room");
`endif

endmodule

/* hw/rtl/utf8_decode_word_counter.sv */
// ----------------------------------------------------------------------------
// utf8_decode_word_counter: UTF-8 decoder with separator flags and counts
// Top level: separator registers, decoder and result queue.
// ----------------------------------------------------------------------------
// Takes one byte per cycle and keeps that rate as long as each byte yields
// at most one output word and the output side is ready; a byte that yields
// two words (an interrupted sequence, or a truncated sequence at end of
// string) puts both on the output channel, one word after the other. A
// byte reaches the output through the input register and then the
// four-word result queue. The decoder moves a byte on only while the
// queue has room for two words, which sets the sustained rate under
// output stalls. Separator registers take a write in any cycle and must only
// be written while no byte is in flight.
module utf8_decode_word_counter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    in_byte_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [utf8d_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [utf8d_pkg::CpW-1:0]     cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          kind_o,
  output logic [utf8d_pkg::CpW-1:0]     code_value_o,
  output logic                          bad_encoding_o,
  output logic                          matches_separator_o,
  output logic [utf8d_pkg::CountW-1:0]  total_codepoints_o,
  output logic [utf8d_pkg::CountW-1:0]  word_chars_o,
  output logic                          last_of_run_o
);
  import utf8d_pkg::*;

  sep_set_t sep_q;
  push_t    push;
  logic     room;
  result_t  head;

  // Separator registers; indexes beyond the last register are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= SepReset;
    end else if (cfg_valid_i && (cfg_index_i < CfgIdxW'(NumSep))) begin
      sep_q[cfg_index_i[SepIdxW-1:0]] <= cfg_data_i;
    end
  end

  utf8d_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .sep_i      (sep_q),
    .room_i     (room),
    .push_o     (push)
  );

  utf8d_result_fifo u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .head_o      (head)
  );

  assign kind_o              = logic'(head.kind);
  assign code_value_o        = head.code_value;
  assign bad_encoding_o      = head.bad_encoding;
  assign matches_separator_o = head.matches_separator;
  assign total_codepoints_o  = head.total_codepoints;
  assign word_chars_o        = head.word_chars;
  assign last_of_run_o       = head.last_of_run;

endmodule
